### sv/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant violated");
// Antecedent in a cycle requires the consequent in the same cycle
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
`else
`define ASSERT_ALWAYS(name, clk, rst_n, expr)
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`endif
`endif

### sv/prrs_pkg.sv
// Shared types and constants of the priority round-robin scheduler.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package prrs_pkg;

    // Fixed field widths of the stream payloads and config port
    localparam int MASK_W     = 16;
    localparam int CUR_W      = 4;
    localparam int OUT_PRIO_W = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Policy codes
    localparam logic [1:0] MODE_RR   = 2'd0;
    localparam logic [1:0] MODE_PRIO = 2'd1;
    localparam logic [1:0] MODE_KEEP = 2'd2;

    // Config register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_POLICY  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DEFAULT = 2'd2;

    // Config reset values
    localparam logic [15:0] PERIOD_RESET  = 16'd250;
    localparam logic [7:0]  DEFAULT_RESET = 8'd10;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // latch the request fields
        logic scan_init;   // set scan start, clear best/found
        logic refresh_wr;  // write default priority at refresh pointer
        logic cur_rd;      // read priority of current entry
        logic dec_wr;      // write back lowered priority of current entry
        logic scan_step;   // read next entry in circular order
        logic finish;      // form result, load output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic prio_mode;
        logic keep_mode;
        logic counter_zero;
        logic need_dec;
        logic refresh_last;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### sv/prrs_ctrl.sv
// Sequencing state machine of the scheduler.
// Depends on prrs_pkg and assert_macros.svh; drives prrs_datapath commands.
`default_nettype none
`include "assert_macros.svh"

module prrs_ctrl
    import prrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_START   = 7'b0000010,
        ST_REFRESH = 7'b0000100,
        ST_RD_CUR  = 7'b0001000,
        ST_DEC     = 7'b0010000,
        ST_SCAN    = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   drain_reg;
    logic   drain_next;

    // State register; drain flag marks the cycle after the last scan read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        drain_next = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.scan_init = 1'b1;
                priority if (status.keep_mode)
                    state_next = ST_FINISH;
                else if (status.prio_mode && status.counter_zero)
                    state_next = ST_REFRESH;
                else if (status.prio_mode && status.need_dec)
                    state_next = ST_RD_CUR;
                else
                    state_next = ST_SCAN;
            end
            ST_REFRESH:
            begin
                cmd.refresh_wr = 1'b1;
                if (status.refresh_last)
                    state_next = status.need_dec ? ST_RD_CUR : ST_SCAN;
            end
            ST_RD_CUR:
            begin
                cmd.cur_rd = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.dec_wr = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // one read per cycle, then the drain flag holds off FINISH until the last read is judged
                if (drain_reg)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.scan_step = 1'b1;
                    drain_next    = status.scan_last;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result is loaded only into a free output register
    `ASSERT_IMPLIES(a_finish_free, clk, rst_n, cmd.finish, status.out_free)
    // Refresh and priority decrement happen only in priority mode
    `ASSERT_IMPLIES(a_refresh_prio, clk, rst_n, cmd.refresh_wr || cmd.dec_wr, status.prio_mode)
    // No new transfer is taken while a request is in flight
    `ASSERT_IMPLIES(a_load_idle, clk, rst_n, cmd.load, $past(cmd.finish) || $past(in_ready))

endmodule

`default_nettype wire

### sv/prrs_datapath.sv
// Datapath of the scheduler: config registers, request latch, priority
// memory, circular scan unit, call counter and output register.
// Depends on prrs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module prrs_datapath
    import prrs_pkg::*;
#(
    parameter int ENTRIES       = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // request fields
    input  logic [MASK_W-1:0]     runnable_mask,
    input  logic                  current_valid,
    input  logic [CUR_W-1:0]      current_index,
    input  logic                  current_running,
    input  logic                  timer_cause,
    // result
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  grant_valid,
    output logic [CUR_W-1:0]      grant_index,
    output logic [OUT_PRIO_W-1:0] grant_priority,
    // control
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status
);

    localparam int          IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int          PB       = PRIORITY_BITS;
    localparam int unsigned PRIO_MAX = (32'd1 << PB) - 32'd1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Config registers
    logic [1:0]            policy_reg;
    logic [15:0]           period_reg;
    logic [7:0]            dflt_cfg_reg;

    // Latched request
    logic [ENTRIES-1:0]    run_vec_reg;
    logic                  cur_ok_reg;
    logic [IDX_W-1:0]      cur_ix_reg;
    logic                  running_reg;
    logic                  timer_reg;

    // Counters and scan state
    logic [15:0]           call_cnt_reg;
    logic [IDX_W-1:0]      ref_idx_reg;
    logic [IDX_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      step_reg;
    logic                  ev_valid_reg;
    logic                  ev_run_reg;
    logic [IDX_W-1:0]      ev_idx_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      pick_reg;
    logic [PB-1:0]         best_reg;

    // Priority memory
    logic [PB-1:0]         prio_mem [ENTRIES];
    logic [PB-1:0]         rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;

    // Output register
    logic                  out_valid_reg;
    logic                  g_valid_reg;
    logic [CUR_W-1:0]      g_idx_reg;
    logic [OUT_PRIO_W-1:0] g_prio_reg;

    logic [ENTRIES-1:0]    run_in;
    logic                  cur_ok_in;
    logic                  mode_rr;
    logic                  mode_prio;
    logic [7:0]            dflt_nz;
    logic [PB-1:0]         dflt;
    logic [IDX_W-1:0]      cur_next_idx;
    logic [IDX_W-1:0]      scan_start;
    logic [IDX_W-1:0]      scan_idx_next;
    logic [IDX_W-1:0]      count_last;
    logic [15:0]           period_eff;
    logic [16:0]           call_cnt_inc;

    // Runnable bits; entries past the mask width are never runnable
    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_run
            if (gi < MASK_W)
            begin : g_in
                assign run_in[gi] = runnable_mask[gi];
            end
            else
            begin : g_out
                assign run_in[gi] = 1'b0;
            end
        end
    endgenerate

    assign cur_ok_in = current_valid && (32'(current_index) < 32'(ENTRIES));

    assign mode_rr   = (policy_reg == MODE_RR);
    assign mode_prio = (policy_reg == MODE_PRIO);

    // Effective default priority: zero acts as one, saturate to PB bits
    assign dflt_nz = (dflt_cfg_reg == 8'd0) ? 8'd1 : dflt_cfg_reg;
    assign dflt    = (32'(dflt_nz) > PRIO_MAX) ? PB'(PRIO_MAX) : PB'(dflt_nz);

    // Circular scan addressing
    assign cur_next_idx  = (cur_ix_reg == LAST_IDX) ? '0 : cur_ix_reg + 1'b1;
    assign scan_start    = cur_ok_reg ? cur_next_idx : '0;
    assign scan_idx_next = (scan_idx_reg == LAST_IDX) ? '0 : scan_idx_reg + 1'b1;
    // round robin skips the current entry
    assign count_last    = (mode_rr && cur_ok_reg) ? LAST_IDX - 1'b1 : LAST_IDX;

    assign period_eff   = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign call_cnt_inc = {1'b0, call_cnt_reg} + 17'd1;

    assign rd_addr = cmd.cur_rd ? cur_ix_reg : scan_idx_reg;

    // Status to controller
    always_comb
    begin
        status.prio_mode    = mode_prio;
        status.keep_mode    = !(mode_rr || mode_prio);
        status.counter_zero = (call_cnt_reg == 16'd0);
        status.need_dec     = cur_ok_reg && timer_reg && run_vec_reg[cur_ix_reg];
        status.refresh_last = (ref_idx_reg == LAST_IDX);
        status.scan_last    = (step_reg == count_last);
        status.out_free     = !out_valid_reg || out_ready;
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg   <= MODE_RR;
            period_reg   <= PERIOD_RESET;
            dflt_cfg_reg <= DEFAULT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_POLICY:  policy_reg   <= cfg_wdata[1:0];
                REG_PERIOD:  period_reg   <= cfg_wdata[15:0];
                REG_DEFAULT: dflt_cfg_reg <= cfg_wdata[7:0];
                default:     ;
            endcase
        end
    end

    // Request latch and pointers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            run_vec_reg <= run_in;
            cur_ok_reg  <= cur_ok_in;
            cur_ix_reg  <= IDX_W'(current_index);
            running_reg <= current_running;
            timer_reg   <= timer_cause;
            ref_idx_reg <= '0;
        end
        else if (cmd.refresh_wr)
        begin
            ref_idx_reg <= ref_idx_reg + 1'b1;
        end

        if (cmd.scan_init)
        begin
            scan_idx_reg <= scan_start;
            step_reg     <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_next;
            step_reg     <= step_reg + 1'b1;
        end

        ev_run_reg <= run_vec_reg[scan_idx_reg];
        ev_idx_reg <= scan_idx_reg;
    end

    // Priority memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.refresh_wr)
            prio_mem[ref_idx_reg] <= dflt;
        else if (cmd.dec_wr && (rd_data_reg > PB'(1)))
            prio_mem[cur_ix_reg] <= rd_data_reg - PB'(1);
        rd_data_reg <= prio_mem[rd_addr];
    end

    // Scan evaluation, one stage behind the memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            pick_reg     <= '0;
            best_reg     <= PB'(1);
        end
        else
        begin
            ev_valid_reg <= cmd.scan_step;
            if (cmd.scan_init)
            begin
                found_reg <= 1'b0;
                best_reg  <= PB'(1);
            end
            else if (ev_valid_reg && ev_run_reg)
            begin
                if (mode_rr)
                begin
                    if (!found_reg)
                    begin
                        found_reg <= 1'b1;
                        pick_reg  <= ev_idx_reg;
                    end
                end
                else if ((rd_data_reg > best_reg) || ((rd_data_reg == best_reg) && !found_reg))
                begin
                    // first entry in scan order at the highest level wins
                    found_reg <= 1'b1;
                    pick_reg  <= ev_idx_reg;
                    best_reg  <= rd_data_reg;
                end
            end
        end
    end

    // Call counter advances once per priority-mode request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            call_cnt_reg <= 16'd0;
        else if (cmd.finish && mode_prio)
            call_cnt_reg <= (call_cnt_inc >= {1'b0, period_eff}) ? 16'd0 : call_cnt_inc[15:0];
    end

    // Output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            g_valid_reg <= 1'b0;
            g_idx_reg   <= '0;
            g_prio_reg  <= '0;
            priority if (mode_rr)
            begin
                if (found_reg)
                begin
                    g_valid_reg <= 1'b1;
                    g_idx_reg   <= CUR_W'(pick_reg);
                end
                else if (cur_ok_reg && running_reg)
                begin
                    // still-running fallback
                    g_valid_reg <= 1'b1;
                    g_idx_reg   <= CUR_W'(cur_ix_reg);
                end
            end
            else if (mode_prio)
            begin
                if (found_reg)
                begin
                    g_valid_reg <= 1'b1;
                    g_idx_reg   <= CUR_W'(pick_reg);
                    g_prio_reg  <= OUT_PRIO_W'(best_reg);
                end
            end
            else if (cur_ok_reg)
            begin
                g_valid_reg <= 1'b1;
                g_idx_reg   <= CUR_W'(cur_ix_reg);
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign grant_valid    = g_valid_reg;
    assign grant_index    = g_idx_reg;
    assign grant_priority = g_prio_reg;

    // Highest level found by the scan is never below one
    `ASSERT_ALWAYS(a_best_nonzero, clk, rst_n, best_reg != '0)
    // A decrement only ever sees a priority of at least one
    `ASSERT_IMPLIES(a_dec_floor, clk, rst_n, cmd.dec_wr, rd_data_reg != '0)
    // Output valid rises only when a result was loaded
    `ASSERT_IMPLIES(a_out_rise, clk, rst_n, $rose(out_valid_reg), $past(cmd.finish))

endmodule

`default_nettype wire

### sv/priority_round_robin_scheduler_top.sv
// Keep-current loads the output register without a scan; round robin scans one
// entry per cycle and skips the current entry; priority mode scans every entry,
// after a refresh when the call counter is zero and a timer decrement when due.
// A request completes before the next is taken; a full output register holds the
// result back and stalls the input. Reset (rst_n, async low) clears control, config
// and call counter; the priority memory is rewritten by the first priority call.
`default_nettype none

module priority_round_robin_scheduler_top
    import prrs_pkg::*;
#(
    parameter int ENTRIES       = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // runnable_mask[15:0], current_valid[16], current_index[20:17],
    // current_running[21], timer_cause[22], zero[23]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // grant stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // grant_valid[0], grant_index[4:1], grant_priority[12:5], zero[15:13]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    ctrl_cmd_t             cmd;
    dp_status_t            status;
    logic                  grant_valid;
    logic [CUR_W-1:0]      grant_index;
    logic [OUT_PRIO_W-1:0] grant_priority;

    prrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    prrs_datapath #(
        .ENTRIES       (ENTRIES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .runnable_mask   (s_axis_tdata[15:0]),
        .current_valid   (s_axis_tdata[16]),
        .current_index   (s_axis_tdata[20:17]),
        .current_running (s_axis_tdata[21]),
        .timer_cause     (s_axis_tdata[22]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .grant_valid     (grant_valid),
        .grant_index     (grant_index),
        .grant_priority  (grant_priority),
        .cmd             (cmd),
        .status          (status)
    );

    // Pack result fields, lowest field first
    assign m_axis_tdata = {3'b000, grant_priority, grant_index, grant_valid};

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for priority_round_robin_scheduler_top.
// Needs prrs_pkg; a scoreboard class predicts every grant, plain tasks drive the streams.
`timescale 1ns / 1ps

module tb_top;
    import prrs_pkg::*;

    localparam int          N_ENTRIES   = 16;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;

    // Expected grant fields
    typedef struct packed {
        logic                  gvalid;
        logic [CUR_W-1:0]      gindex;
        logic [OUT_PRIO_W-1:0] gprio;
    } grant_t;

    // Grant predictor and store of pending grants
    class grant_scoreboard;
        logic [1:0]            mode;
        logic [15:0]           period;
        logic [7:0]            dflt;
        logic [OUT_PRIO_W-1:0] prio_tbl [N_ENTRIES];
        logic [15:0]           calls;
        grant_t                grants_q [$];
        int                    errors;

        function new();
            mode   = MODE_RR;
            period = PERIOD_RESET;
            dflt   = DEFAULT_RESET;
            calls  = '0;
            errors = 0;
            refresh_table();
        endfunction

        function void write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
            if (addr == REG_POLICY)
                mode = val[1:0];
            else if (addr == REG_PERIOD)
                period = val;
            else if (addr == REG_DEFAULT)
                dflt = val[7:0];
        endfunction

        // A zero default acts as one
        function void refresh_table();
            for (int i = 0; i < N_ENTRIES; i++)
                prio_tbl[i] = (dflt == 0) ? 8'd1 : dflt;
        endfunction

        function grant_t predict_grant(input logic [IN_DATA_W-1:0] d);
            logic [MASK_W-1:0]     mask;
            logic                  cv;
            logic [CUR_W-1:0]      ci;
            logic                  run;
            logic                  tmr;
            logic [CUR_W-1:0]      idx;
            logic [OUT_PRIO_W-1:0] top;
            logic [16:0]           per;
            grant_t                g;
            mask = d[15:0];
            cv   = d[16];
            ci   = d[20:17];
            run  = d[21];
            tmr  = d[22];
            g    = '0;
            if (mode == MODE_RR)
            begin
                // circular scan after the current entry, which is skipped
                for (int k = 0; k < N_ENTRIES; k++)
                begin
                    idx = cv ? ci + k[3:0] : k[3:0];
                    if (!g.gvalid && (!cv || k > 0) && mask[idx])
                    begin
                        g.gvalid = 1'b1;
                        g.gindex = idx;
                    end
                end
                // still-running fallback
                if (!g.gvalid && cv && run)
                begin
                    g.gvalid = 1'b1;
                    g.gindex = ci;
                end
            end
            else if (mode == MODE_PRIO)
            begin
                if (calls == 0)
                    refresh_table();
                // timer aging of a runnable current entry, floor of one
                if (cv && tmr && mask[ci] && prio_tbl[ci] > 1)
                    prio_tbl[ci] = prio_tbl[ci] - 1'b1;
                top = 8'd1;
                for (int i = 0; i < N_ENTRIES; i++)
                    if (mask[i] && prio_tbl[i] > top)
                        top = prio_tbl[i];
                // scan from current+1, current entry last
                for (int k = 0; k < N_ENTRIES; k++)
                begin
                    idx = cv ? ci + 4'd1 + k[3:0] : k[3:0];
                    if (!g.gvalid && mask[idx] && prio_tbl[idx] == top)
                    begin
                        g.gvalid = 1'b1;
                        g.gindex = idx;
                        g.gprio  = top;
                    end
                end
                per = (period == 0) ? 17'd1 : {1'b0, period};
                if ({1'b0, calls} + 17'd1 >= per)
                    calls = '0;
                else
                    calls = calls + 1'b1;
            end
            else if (cv)
            begin
                // keep current, also for the unused mode code
                g.gvalid = 1'b1;
                g.gindex = ci;
            end
            return g;
        endfunction

        function void note_request(input logic [IN_DATA_W-1:0] d);
            grants_q.push_back(predict_grant(d));
        endfunction

        task report_mismatch(input string what, input int got, input int exp);
            $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, exp);
            errors++;
        endtask

        task check_grant(input logic [OUT_DATA_W-1:0] d);
            grant_t e;
            if (grants_q.size() == 0)
            begin
                report_mismatch("grant with none pending, data", d, 0);
                return;
            end
            e = grants_q.pop_front();
            if (d[0] !== e.gvalid)
                report_mismatch("grant_valid", d[0], e.gvalid);
            if (d[4:1] !== e.gindex)
                report_mismatch("grant_index", d[4:1], e.gindex);
            if (d[12:5] !== e.gprio)
                report_mismatch("grant_priority", d[12:5], e.gprio);
        endtask

        function int pending();
            return grants_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // runnable_mask[15:0], current_valid[16], current_index[20:17],
    // current_running[21], timer_cause[22], zero[23]
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // grant_valid[0], grant_index[4:1], grant_priority[12:5], zero[15:13]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    grant_scoreboard sb;
    bit              tx_idle_on;
    bit              rx_idle_on;
    bit              hold_req;
    int              cycles;

    priority_round_robin_scheduler_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                m_axis_tready <= rx_idle_on ? ($urandom_range(0, 99) >= 32) : 1'b1;
            end
        end
    end

    // Grant monitor, sampled mid-cycle where signals are stable
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_grant(m_axis_tdata);
    end

    function automatic logic [IN_DATA_W-1:0] pack_request(input logic [15:0] mask,
        input logic cv, input logic [3:0] ci, input logic run, input logic tmr);
        return {1'b0, tmr, run, ci, cv, mask};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_request();
        logic [15:0] mask;
        logic        cv;
        logic [3:0]  ci;
        case ($urandom_range(0, 9))
            0:       mask = '0;
            1:       mask = 16'hFFFF;
            2:       mask = 16'h1 << $urandom_range(0, 15);
            3:       mask = 16'($urandom() & $urandom());
            default: mask = 16'($urandom());
        endcase
        cv = ($urandom_range(0, 3) != 0);
        ci = 4'($urandom_range(0, 15));
        // current entry usually runnable, so timer aging takes effect
        if (cv && $urandom_range(0, 9) < 6)
            mask[ci] = 1'b1;
        return pack_request(mask, cv, ci, 1'($urandom_range(0, 1)),
                            $urandom_range(0, 2) != 0);
    endfunction

    // One request transfer; called and returns at a rising edge
    task automatic send_request(input logic [IN_DATA_W-1:0] d);
        if (tx_idle_on && $urandom_range(0, 99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
            @(negedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        sb.note_request(d);
        @(posedge clk);
    endtask

    // Stop offering and wait for every pending grant
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        sb.write_reg(addr, val);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] mode, input logic [15:0] per,
        input logic [15:0] dflt);
        drain();
        write_reg(REG_POLICY, {14'd0, mode});
        write_reg(REG_PERIOD, per);
        write_reg(REG_DEFAULT, dflt);
    endtask

    task automatic run_phase(input logic [1:0] mode, input logic [15:0] per,
        input logic [15:0] dflt, input int n, input bit idle, input bit hold);
        configure(mode, per, dflt);
        tx_idle_on = idle;
        rx_idle_on = idle;
        for (int i = 0; i < n; i++)
        begin
            if (hold && i == n / 3)
                hold_req = 1'b1;
            send_request(random_request());
        end
    endtask

    // Main sequence
    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_req      = 1'b0;
        cycles        = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Round robin from reset settings
        send_request(pack_request(16'h0000, 1'b0, 4'd0, 1'b1, 1'b0));  // halt
        send_request(pack_request(16'h0000, 1'b1, 4'd6, 1'b1, 1'b0));  // running fallback
        send_request(pack_request(16'h0000, 1'b1, 4'd6, 1'b0, 1'b0));  // halt
        send_request(pack_request(16'h0040, 1'b1, 4'd6, 1'b1, 1'b1));  // current excluded
        send_request(pack_request(16'h0040, 1'b1, 4'd6, 1'b0, 1'b1));  // current excluded, halt
        send_request(pack_request(16'hFFFF, 1'b1, 4'd15, 1'b0, 1'b0)); // wraps to 0
        send_request(pack_request(16'hFFFF, 1'b0, 4'd9, 1'b0, 1'b0));  // from 0
        send_request(pack_request(16'h8000, 1'b1, 4'd0, 1'b0, 1'b0));  // top entry

        // Priority mode: aging, ties, halt, floor of one
        configure(MODE_PRIO, 16'd250, 16'd10);
        send_request(pack_request(16'hFFFF, 1'b1, 4'd3, 1'b1, 1'b1));
        send_request(pack_request(16'h0008, 1'b1, 4'd3, 1'b1, 1'b1));
        send_request(pack_request(16'h0000, 1'b1, 4'd3, 1'b1, 1'b1));  // halt
        send_request(pack_request(16'h0009, 1'b1, 4'd3, 1'b1, 1'b0));
        send_request(pack_request(16'h0008, 1'b0, 4'd3, 1'b1, 1'b1));  // no current
        configure(MODE_PRIO, 16'd0, 16'd1);                            // refresh every call
        send_request(pack_request(16'hFFFF, 1'b1, 4'd15, 1'b1, 1'b1));
        send_request(pack_request(16'h8001, 1'b1, 4'd15, 1'b0, 1'b1));
        configure(MODE_PRIO, 16'd2, 16'd0);                            // zero default
        send_request(pack_request(16'h00F0, 1'b1, 4'd5, 1'b1, 1'b1));
        send_request(pack_request(16'h00F0, 1'b1, 4'd5, 1'b1, 1'b1));
        configure(MODE_PRIO, 16'hFFFF, 16'h00FF);
        send_request(pack_request(16'hFFFF, 1'b1, 4'd0, 1'b1, 1'b1));

        // Keep current and the unused mode code
        configure(MODE_KEEP, 16'd250, 16'd10);
        send_request(pack_request(16'h0000, 1'b1, 4'd11, 1'b0, 1'b0));
        send_request(pack_request(16'hFFFF, 1'b0, 4'd11, 1'b1, 1'b1)); // halt
        configure(MODE_UNUSED, 16'd250, 16'd10);
        send_request(pack_request(16'h1234, 1'b1, 4'd2, 1'b0, 1'b1));
        send_request(pack_request(16'h1234, 1'b0, 4'd2, 1'b1, 1'b0));  // halt

        // Random phases; counter carries over when the period shrinks
        run_phase(MODE_RR,     16'd250,   16'd10,    130, 1'b1, 1'b0);
        run_phase(MODE_PRIO,   16'd250,   16'd10,    200, 1'b1, 1'b1);
        run_phase(MODE_PRIO,   16'd7,     16'd10,    130, 1'b1, 1'b0);
        run_phase(MODE_PRIO,   16'd1,     16'd3,      80, 1'b1, 1'b0);
        run_phase(MODE_PRIO,   16'd0,     16'd4,      80, 1'b1, 1'b0);
        run_phase(MODE_PRIO,   16'hFFFF,  16'd255,   150, 1'b0, 1'b0);
        run_phase(MODE_PRIO,   16'd20,    16'd0,     100, 1'b1, 1'b0);
        run_phase(MODE_PRIO,   16'd40,    16'h01FF,  100, 1'b1, 1'b0);
        run_phase(MODE_KEEP,   16'd9,     16'd6,     100, 1'b1, 1'b1);
        run_phase(MODE_UNUSED, 16'd250,   16'd10,     80, 1'b1, 1'b0);
        run_phase(MODE_RR,     16'd5,     16'd1,     150, 1'b1, 1'b0);
        run_phase(MODE_PRIO,   16'd3,     16'd2,     200, 1'b1, 1'b0);
        run_phase(MODE_PRIO,   16'd100,   16'd1,     100, 1'b1, 1'b0);

        // Wind down
        drain();
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
